### design/cmla_pkg.sv
`timescale 1ns / 1ps
// Package for the conflict-mask lease arbiter: item types, codes, reset values.
// No dependencies; used by every module of the block.
package cmla_pkg;

    localparam int NUM_RES  = 7;
    localparam int RES_W    = 3;
    localparam int TICKET_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [RES_W-1:0] NONE_CODE = RES_W'(NUM_RES);

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DENIED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

    localparam logic [NUM_RES-1:0] BLOCKER_RESET [NUM_RES] = '{
        7'd63, 7'd63, 7'd63, 7'd63, 7'd127, 7'd127, 7'd112
    };

    typedef struct packed {
        logic                cmd;
        logic [RES_W-1:0]    resource;
        logic [TICKET_W-1:0] ticket;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICKET_W-1:0] granted_ticket;
        logic [RES_W-1:0]    blocking_resource;
        logic [NUM_RES-1:0]  held_now;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic commit;
    } dp_cmd_t;

endpackage

### design/cmla_ctrl.sv
`timescale 1ns / 1ps
// Controller for the conflict-mask lease arbiter: input/output handshake FSM.
// Depends on cmla_pkg.
module cmla_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cmla_pkg::dp_cmd_t dp_cmd
);

    cmla_pkg::ctl_state_t state_reg;
    cmla_pkg::ctl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmla_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        in_ready          = 1'b0;
        dp_cmd.load_req   = 1'b0;
        dp_cmd.commit     = 1'b0;

        // result taken this cycle
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cmla_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.load_req = 1'b1;
                    state_next      = cmla_pkg::ST_EXEC;
                end
            end
            cmla_pkg::ST_EXEC:
            begin
                // output register free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.commit  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cmla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmla_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // A commit never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit over pending result");

    // Every accepted item is followed by a commit cycle before the next accept
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_req |=> !in_ready)
        else $error("second item accepted before commit");

    // A commit always leaves a valid result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> out_valid)
        else $error("commit produced no result");

endmodule

### design/cmla_dpath.sv
`timescale 1ns / 1ps
// Datapath for the conflict-mask lease arbiter: blocker registers, held mask,
// lease store, ticket counter and the result register. Depends on cmla_pkg.
module cmla_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cmla_pkg::RES_W-1:0]      cfg_index,
    input  logic [cmla_pkg::NUM_RES-1:0]    cfg_data,
    input  cmla_pkg::in_item_t              in_data,
    input  cmla_pkg::dp_cmd_t               dp_cmd,
    output cmla_pkg::out_item_t             out_data
);

    logic [cmla_pkg::NUM_RES-1:0]  blockers_reg [cmla_pkg::NUM_RES];
    logic [cmla_pkg::NUM_RES-1:0]  held_reg;
    logic [cmla_pkg::NUM_RES-1:0]  held_next;
    logic [cmla_pkg::TICKET_W-1:0] lease_reg [cmla_pkg::NUM_RES];
    logic [cmla_pkg::TICKET_W-1:0] counter_reg;
    logic [cmla_pkg::TICKET_W-1:0] counter_next;
    cmla_pkg::in_item_t            req_reg;
    cmla_pkg::out_item_t           out_reg;
    cmla_pkg::out_item_t           out_next;

    logic                          in_range;
    logic [cmla_pkg::RES_W-1:0]    res_idx;
    logic [cmla_pkg::NUM_RES-1:0]  conflicts;
    logic [cmla_pkg::RES_W-1:0]    lowest;
    logic                          grant;
    logic                          release_ok;

    // Blocker masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cmla_pkg::NUM_RES; i++)
            begin
                blockers_reg[i] <= cmla_pkg::BLOCKER_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < cmla_pkg::NONE_CODE))
        begin
            blockers_reg[cfg_index] <= cfg_data;
        end
    end

    // Request and result registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_req)
        begin
            req_reg <= in_data;
        end
        if (dp_cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    // Lease store: only read where the held bit is set, so no reset needed
    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit && grant)
        begin
            lease_reg[res_idx] <= counter_reg;
        end
        else if (dp_cmd.commit && release_ok)
        begin
            lease_reg[res_idx] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            counter_reg <= cmla_pkg::TICKET_W'(1);
        end
        else if (dp_cmd.commit)
        begin
            held_reg    <= held_next;
            counter_reg <= counter_next;
        end
    end

    assign in_range  = (req_reg.resource < cmla_pkg::NONE_CODE);
    assign res_idx   = in_range ? req_reg.resource : '0;
    assign conflicts = held_reg & blockers_reg[res_idx];

    // lowest set bit of the conflict mask
    always_comb
    begin
        lowest = cmla_pkg::NONE_CODE;
        for (int i = cmla_pkg::NUM_RES - 1; i >= 0; i--)
        begin
            if (conflicts[i])
            begin
                lowest = cmla_pkg::RES_W'(i);
            end
        end
    end

    assign grant      = (req_reg.cmd == cmla_pkg::CMD_ACQUIRE) && in_range
                        && (conflicts == '0);
    assign release_ok = (req_reg.cmd == cmla_pkg::CMD_RELEASE) && in_range
                        && held_reg[res_idx] && (lease_reg[res_idx] == req_reg.ticket);

    // counter skips zero on wrap
    assign counter_next = !grant ? counter_reg
                        : (counter_reg == '1) ? cmla_pkg::TICKET_W'(1)
                        : counter_reg + cmla_pkg::TICKET_W'(1);

    always_comb
    begin
        held_next = held_reg;
        if (grant)
        begin
            held_next[res_idx] = 1'b1;
        end
        else if (release_ok)
        begin
            held_next[res_idx] = 1'b0;
        end
    end

    always_comb
    begin
        out_next.granted_ticket    = '0;
        out_next.blocking_resource = cmla_pkg::NONE_CODE;
        out_next.held_now          = held_next;
        if (req_reg.cmd == cmla_pkg::CMD_ACQUIRE)
        begin
            if (grant)
            begin
                out_next.status         = cmla_pkg::ST_GRANTED;
                out_next.granted_ticket = counter_reg;
            end
            else
            begin
                out_next.status = cmla_pkg::ST_DENIED;
                if (in_range)
                begin
                    out_next.blocking_resource = lowest;
                end
            end
        end
        else
        begin
            out_next.status = release_ok ? cmla_pkg::ST_RELEASED : cmla_pkg::ST_MISMATCH;
        end
    end

    assign out_data = out_reg;

    // The ticket counter never reaches zero
    assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != '0)
        else $error("ticket counter is zero");

    // A grant hands out a nonzero lease
    assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.commit && grant) |=> (out_data.granted_ticket != '0))
        else $error("zero lease granted");

    // Held mask and counter move only on a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        !dp_cmd.commit |=> ($stable(held_reg) && $stable(counter_reg)))
        else $error("state changed without commit");

endmodule

### design/conflict_mask_lease_arbiter.sv
`timescale 1ns / 1ps
// Conflict-mask lease arbiter top level: controller plus datapath.
// Depends on cmla_pkg, cmla_ctrl and cmla_dpath.
//
// Lock manager for seven resources. An acquire (cmd 0) is granted when no held
// resource lies in the requested resource's blocker mask; the grant sets the
// held bit and hands out a lease number from a 32-bit counter that starts at
// one and skips zero when it wraps. A denial reports the lowest blocking held
// resource (7 when the resource index itself is out of range). A release
// (cmd 1) frees the resource only if it is held and the presented lease
// matches; anything else is a release mismatch with no state change. Each
// result item carries the held mask after the step. An item is captured, then
// evaluated against the held mask and committed with the lease update; the
// commit waits while the output register holds an untaken result, but a new
// item is accepted while a finished result waits. Blocker masks are written
// through cfg_we/cfg_index/cfg_data (index 0..6, index 7 ignored) by the user
// only while the block is idle; the block does not enforce this. Reset values
// are 63, 63, 63, 63, 127, 127, 112. No clearing pass follows reset.
module conflict_mask_lease_arbiter (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [cmla_pkg::RES_W-1:0]   cfg_index,
    input  logic [cmla_pkg::NUM_RES-1:0] cfg_data,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cmla_pkg::in_item_t           in_data,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output cmla_pkg::out_item_t          out_data
);

    cmla_pkg::dp_cmd_t dp_cmd;

    // Handshake sequencing: capture, then commit into the output register
    cmla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    // Mask check, priority encode, lease store and counter
    cmla_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .dp_cmd    (dp_cmd),
        .out_data  (out_data)
    );

endmodule

### tb/sv/conflict_mask_lease_arbiter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for conflict_mask_lease_arbiter: a bursty request driver,
// a stalling result sink and an in-line lease/held-mask predictor checked per field.
// Depends on cmla_pkg and the conflict_mask_lease_arbiter RTL.
module conflict_mask_lease_arbiter_test;

    localparam int                          SETTLE_CYCLES    = 6;
    localparam int                          WATCHDOG_LIMIT   = 2000;
    localparam int                          RANDOM_PHASES    = 10;
    localparam int                          ITEMS_PER_PHASE  = 120;
    localparam logic [cmla_pkg::RES_W-1:0]  UNUSED_CFG_INDEX = 3'd7;
    localparam logic [cmla_pkg::RES_W-1:0]  BAD_RESOURCE     = 3'd7;

    // How the driver fills in a queued request when it is popped.
    // Release kinds pick a held resource, if any, and its live lease at that moment,
    // so well-formed acquire/release chains get through; the stale kind then flips one lease bit.
    typedef enum logic [1:0] {
        RK_LITERAL,
        RK_RELEASE_HELD,
        RK_RELEASE_STALE
    } req_kind_t;

    typedef struct packed {
        req_kind_t          kind;
        cmla_pkg::in_item_t req;
    } backlog_entry_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [cmla_pkg::RES_W-1:0]      cfg_index = '0;
    logic [cmla_pkg::NUM_RES-1:0]    cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    cmla_pkg::in_item_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    cmla_pkg::out_item_t             out_data;

    // Predictor state: mirrors the arbiter's held mask, leases and counter
    logic [cmla_pkg::NUM_RES-1:0]    blocker_cfg [cmla_pkg::NUM_RES];
    logic [cmla_pkg::NUM_RES-1:0]    held_mask;
    logic [cmla_pkg::TICKET_W-1:0]   lease_of    [cmla_pkg::NUM_RES];
    logic [cmla_pkg::TICKET_W-1:0]   next_lease;

    logic [cmla_pkg::NUM_RES-1:0]    next_blockers [cmla_pkg::NUM_RES];

    backlog_entry_t                  request_backlog [$];
    cmla_pkg::out_item_t             awaited_results [$];

    int                  requests_queued = 0;
    int                  requests_taken  = 0;
    int                  failures        = 0;
    int                  quiet_cycles    = 0;
    logic                in_acc          = 1'b0;

    // Sender burst shaping
    int                  burst_left = 1;
    int                  gap_left   = 0;

    // Receiver stall pattern
    int                  stall_mode = 0;
    int                  mode_left  = 0;
    int                  ready_tick = 0;

    always #2 clk = ~clk;

    conflict_mask_lease_arbiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Works out the result of one accepted request and advances the lease state.
    function automatic cmla_pkg::out_item_t settle_request(input cmla_pkg::in_item_t req);
        cmla_pkg::out_item_t          res;
        logic [cmla_pkg::NUM_RES-1:0] clash;
        res.status            = cmla_pkg::ST_MISMATCH;
        res.granted_ticket    = '0;
        res.blocking_resource = cmla_pkg::NONE_CODE;
        if (req.cmd == cmla_pkg::CMD_ACQUIRE)
        begin
            if (req.resource >= cmla_pkg::NUM_RES)
                res.status = cmla_pkg::ST_DENIED;   // out-of-range resource: denied, none blocks
            else
            begin
                clash = held_mask & blocker_cfg[req.resource];
                if (clash != '0)
                begin
                    res.status = cmla_pkg::ST_DENIED;
                    // lowest held resource in the blocker mask wins
                    for (int i = cmla_pkg::NUM_RES - 1; i >= 0; i--)
                        if (clash[i])
                            res.blocking_resource = cmla_pkg::RES_W'(i);
                end
                else
                begin
                    res.status                = cmla_pkg::ST_GRANTED;
                    res.granted_ticket        = next_lease;
                    lease_of[req.resource]    = next_lease;
                    held_mask[req.resource]   = 1'b1;
                    next_lease                = next_lease + cmla_pkg::TICKET_W'(1);
                    if (next_lease == '0)
                        next_lease = cmla_pkg::TICKET_W'(1);   // counter skips zero on wrap
                end
            end
        end
        else if (req.resource < cmla_pkg::NUM_RES && held_mask[req.resource] &&
                 lease_of[req.resource] == req.ticket)
        begin
            res.status              = cmla_pkg::ST_RELEASED;
            held_mask[req.resource] = 1'b0;
            lease_of[req.resource]  = '0;
        end
        res.held_now = held_mask;
        return res;
    endfunction

    // Request driver: changes inputs at the falling edge, pops the backlog
    // only once the previous item was taken.
    always @(negedge clk)
    begin : drive_requests
        backlog_entry_t     nxt;
        cmla_pkg::in_item_t pick;
        int                 start;
        int                 idx;
        logic               found;
        if (rst_n && (!in_valid || in_acc))
        begin
            if (gap_left > 0 || request_backlog.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                nxt  = request_backlog.pop_front();
                pick = nxt.req;
                if (nxt.kind != RK_LITERAL)
                begin
                    // release a currently held resource if there is one
                    start = $urandom_range(0, cmla_pkg::NUM_RES - 1);
                    found = 1'b0;
                    for (int k = 0; k < cmla_pkg::NUM_RES; k++)
                    begin
                        idx = (start + k) % cmla_pkg::NUM_RES;
                        if (!found && held_mask[idx])
                        begin
                            pick.resource = cmla_pkg::RES_W'(idx);
                            found         = 1'b1;
                        end
                    end
                    pick.cmd    = cmla_pkg::CMD_RELEASE;
                    pick.ticket = lease_of[pick.resource];
                    if (nxt.kind == RK_RELEASE_STALE)
                        pick.ticket = pick.ticket ^ (32'd1 << $urandom_range(0, 31));
                end
                in_valid <= 1'b1;
                in_data  <= pick;
                burst_left--;
                if (burst_left <= 0)
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 10);
                end
            end
        end
    end

    // Result sink: ready follows a mode that changes every so often
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end
            else
                mode_left--;
            ready_tick++;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((ready_tick % 5) < 2);
            endcase
        end
    end

    // Monitor: predicts on request accept, checks on result accept, watchdog
    always @(posedge clk)
    begin : watch_ports
        cmla_pkg::out_item_t want;
        if (rst_n)
        begin
            in_acc <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(settle_request(in_data));
                requests_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result item: status %0d held_now %b",
                           out_data.status, out_data.held_now);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        failures++;
                    end
                    if (out_data.granted_ticket !== want.granted_ticket)
                    begin
                        $error("granted_ticket: expected %0h, got %0h",
                               want.granted_ticket, out_data.granted_ticket);
                        failures++;
                    end
                    if (out_data.blocking_resource !== want.blocking_resource)
                    begin
                        $error("blocking_resource: expected %0d, got %0d",
                               want.blocking_resource, out_data.blocking_resource);
                        failures++;
                    end
                    if (out_data.held_now !== want.held_now)
                    begin
                        $error("held_now: expected %b, got %b", want.held_now, out_data.held_now);
                        failures++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("conflict_mask_lease_arbiter_test: errors");
                $finish;
            end
        end
    end

    task automatic queue_req(input req_kind_t kind, input logic cmd,
                             input logic [cmla_pkg::RES_W-1:0] res,
                             input logic [cmla_pkg::TICKET_W-1:0] tkt);
        backlog_entry_t e;
        e.kind         = kind;
        e.req.cmd      = cmd;
        e.req.resource = res;
        e.req.ticket   = tkt;
        request_backlog.push_back(e);
        requests_queued++;
    endtask

    // Mix of acquires, correct releases, stale releases and raw noise
    task automatic queue_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE,
                      (r < 3) ? BAD_RESOURCE
                              : cmla_pkg::RES_W'($urandom_range(0, cmla_pkg::NUM_RES - 1)),
                      $urandom);
        else if (r < 75)
            queue_req(RK_RELEASE_HELD, cmla_pkg::CMD_RELEASE,
                      cmla_pkg::RES_W'($urandom_range(0, cmla_pkg::NUM_RES - 1)), '0);
        else if (r < 85)
            queue_req(RK_RELEASE_STALE, cmla_pkg::CMD_RELEASE,
                      cmla_pkg::RES_W'($urandom_range(0, cmla_pkg::NUM_RES - 1)), '0);
        else
            queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE,
                      cmla_pkg::RES_W'($urandom_range(0, 7)),
                      (r < 93) ? cmla_pkg::TICKET_W'($urandom_range(0, 64)) : $urandom);
    endtask

    // Writes next_blockers into all seven registers; optionally pokes the unused index
    task automatic load_blockers(input bit poke_unused);
        for (int i = 0; i < cmla_pkg::NUM_RES; i++)
        begin
            @(negedge clk);
            cfg_we         <= 1'b1;
            cfg_index      <= cmla_pkg::RES_W'(i);
            cfg_data       <= next_blockers[i];
            blocker_cfg[i]  = next_blockers[i];
        end
        if (poke_unused)
        begin
            @(negedge clk);
            cfg_index <= UNUSED_CFG_INDEX;
            cfg_data  <= cmla_pkg::NUM_RES'($urandom_range(0, 127));   // must be ignored
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Block is idle once every queued request was taken and every result seen
    task automatic drain_block();
        while (requests_taken != requests_queued || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : run_phases
        held_mask  = '0;
        next_lease = cmla_pkg::TICKET_W'(1);
        for (int i = 0; i < cmla_pkg::NUM_RES; i++)
        begin
            blocker_cfg[i] = cmla_pkg::BLOCKER_RESET[i];
            lease_of[i]    = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset masks: 63 x4, 127 x2, 112
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd0, 32'hFFFF_FFFF);  // grant, lease 1
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd1, 32'h0);          // blocked by 0
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd6, 32'h0);          // grant, lease 2
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd6, 32'h0);          // blocked by itself
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, BAD_RESOURCE, 32'h0);  // out of range
        queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE, BAD_RESOURCE, 32'd1);  // out of range
        queue_req(RK_RELEASE_STALE, cmla_pkg::CMD_RELEASE, 3'd0, 32'h0);    // wrong lease
        queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE, 3'd6, 32'd2);          // released
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd4, 32'h0);          // blocked by 0
        queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE, 3'd0, 32'd1);          // released
        queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE, 3'd0, 32'd0);          // not held
        queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE, 3'd3, 32'hFFFF_FFFF);  // not held
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd4, 32'h0);          // grant, lease 3
        queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, 3'd5, 32'h0);          // blocked by 4
        queue_req(RK_LITERAL, cmla_pkg::CMD_RELEASE, 3'd4, 32'd3);          // released
        drain_block();

        // No blockers at all: everything can be held at once
        for (int i = 0; i < cmla_pkg::NUM_RES; i++)
            next_blockers[i] = '0;
        load_blockers(1'b1);
        for (int i = 0; i < cmla_pkg::NUM_RES; i++)
            queue_req(RK_LITERAL, cmla_pkg::CMD_ACQUIRE, cmla_pkg::RES_W'(i), $urandom);
        repeat (3) queue_req(RK_RELEASE_HELD, cmla_pkg::CMD_RELEASE, 3'd0, '0);
        drain_block();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int i = 0; i < cmla_pkg::NUM_RES; i++)
                case (ph)
                    0:       next_blockers[i] = '1;                          // all exclusive
                    1:       next_blockers[i] = '0;
                    2:       next_blockers[i] = cmla_pkg::NUM_RES'(1) << i;  // self only
                    3:       next_blockers[i] = cmla_pkg::BLOCKER_RESET[i];
                    4:       next_blockers[i] = cmla_pkg::NUM_RES'($urandom_range(0, 127) &
                                                                   $urandom_range(0, 127));
                    default: next_blockers[i] = cmla_pkg::NUM_RES'($urandom_range(0, 127));
                endcase
            load_blockers($urandom_range(0, 2) == 0);
            repeat (ITEMS_PER_PHASE) queue_random_request();
            drain_block();
        end

        if (failures == 0 && awaited_results.size() == 0)
            $display("conflict_mask_lease_arbiter_test: clean");
        else
            $display("conflict_mask_lease_arbiter_test: errors");
        $finish;
    end

endmodule
